FILE: rtl/fca_pkg.sv
// Shared types, register indexes and helpers for the FAT16 cluster address unit.
`timescale 1ns / 1ps

package fca_pkg;

  localparam int unsigned ClusterW  = 16;
  localparam int unsigned EntryW    = 16;
  localparam int unsigned LbaW      = 32;
  localparam int unsigned OffsetW   = 12;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ShiftW    = 4;
  localparam int unsigned CshW      = 3;
  localparam int unsigned FirstDataW = 25;
  localparam int unsigned RootSecW  = 13;
  localparam int unsigned ProdW     = 24;

  localparam logic [CfgIdxW-1:0] RegSectorLog2   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegClusterLog2  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReserved     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFatCopies    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFatLength    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRootEntries  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegVolumeSecs   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegPartBase     = 3'd7;

  localparam logic [ClusterW-1:0] EndMark      = 16'hFFFF;
  localparam logic [EntryW-1:0]   EocMin       = 16'hFFF8;
  localparam logic [ClusterW-1:0] FirstCluster = 16'd2;
  localparam logic [ShiftW-1:0]   MinShift     = 4'd9;
  localparam logic [ShiftW-1:0]   MaxShift     = 4'd12;

  typedef struct packed {
    logic [ShiftW-1:0]   sector_size_log2;
    logic [CshW-1:0]     cluster_size_log2;
    logic [15:0]         reserved_sectors;
    logic [7:0]          fat_copies;
    logic [15:0]         fat_length;
    logic [15:0]         root_entries;
    logic [15:0]         volume_sectors;
    logic [LbaW-1:0]     partition_base;
  } cfg_t;

  function automatic logic [ShiftW-1:0] eff_shift(input logic [ShiftW-1:0] raw);
    logic [ShiftW-1:0] res;
    if (raw < MinShift) begin
      res = MinShift;
    end else if (raw > MaxShift) begin
      res = MaxShift;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

FILE: rtl/fca_cfg_regs.sv
// Configuration register file holding the boot-record geometry.
`timescale 1ns / 1ps

module fca_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fca_pkg::CfgDataW-1:0] cfg_wdata_i,
  output fca_pkg::cfg_t                cfg_o
);
  import fca_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSectorLog2:  cfg_d.sector_size_log2  = cfg_wdata_i[ShiftW-1:0];
        RegClusterLog2: cfg_d.cluster_size_log2 = cfg_wdata_i[CshW-1:0];
        RegReserved:    cfg_d.reserved_sectors  = cfg_wdata_i[15:0];
        RegFatCopies:   cfg_d.fat_copies        = cfg_wdata_i[7:0];
        RegFatLength:   cfg_d.fat_length        = cfg_wdata_i[15:0];
        RegRootEntries: cfg_d.root_entries      = cfg_wdata_i[15:0];
        RegVolumeSecs:  cfg_d.volume_sectors    = cfg_wdata_i[15:0];
        RegPartBase:    cfg_d.partition_base    = cfg_wdata_i[LbaW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sector_size_log2  <= 4'd9;
      cfg_q.cluster_size_log2 <= 3'd0;
      cfg_q.reserved_sectors  <= 16'd1;
      cfg_q.fat_copies        <= 8'd2;
      cfg_q.fat_length        <= 16'd0;
      cfg_q.root_entries      <= 16'd512;
      cfg_q.volume_sectors    <= 16'd0;
      cfg_q.partition_base    <= 32'd2048;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/fca_pipe.sv
// Four-stage translation pipeline from cluster number to sector addresses.
`timescale 1ns / 1ps

module fca_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fca_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  input  logic [fca_pkg::ClusterW-1:0] cluster_i,
  input  logic [fca_pkg::EntryW-1:0]   raw_entry_i,
  output logic                         out_valid_o,
  output logic [fca_pkg::LbaW-1:0]     data_lba_o,
  output logic [fca_pkg::LbaW-1:0]     table_lba_o,
  output logic [fca_pkg::OffsetW-1:0]  entry_offset_o,
  output logic                         in_range_o,
  output logic [fca_pkg::ClusterW-1:0] next_cluster_o,
  output logic                         chain_end_o,
  output logic [fca_pkg::ClusterW-1:0] cluster_count_o
);
  import fca_pkg::*;

  // Stage 1: product, root directory size, FAT entry position
  logic                   s1_valid_q;
  logic [ClusterW-1:0]    s1_cl_q;
  logic [EntryW-1:0]      s1_raw_q;
  logic [ProdW-1:0]       s1_prod_q;
  logic [RootSecW-1:0]    s1_root_q;
  logic [7:0]             s1_hi_q;
  logic [OffsetW-1:0]     s1_off_q;

  logic [ShiftW-1:0]      sh;
  logic [12:0]            bps_m1;
  logic [OffsetW-1:0]     off_mask;
  logic [21:0]            root_bytes;
  logic [21:0]            root_shr;
  logic [16:0]            byte_off;
  logic [16:0]            hi_shr;

  always_comb begin
    sh         = eff_shift(cfg_i.sector_size_log2);
    bps_m1     = (13'd1 << sh) - 13'd1;
    off_mask   = bps_m1[OffsetW-1:0];
    root_bytes = {1'b0, cfg_i.root_entries, 5'b0} + {9'd0, bps_m1};
    root_shr   = root_bytes >> sh;
    byte_off   = {cluster_i, 1'b0};
    hi_shr     = byte_off >> sh;
  end

  // Stage 2: first data sector and FAT sector address
  logic                   s2_valid_q;
  logic [ClusterW-1:0]    s2_cl_q;
  logic [EntryW-1:0]      s2_raw_q;
  logic [FirstDataW-1:0]  s2_fd_q;
  logic [LbaW-1:0]        s2_tlba_q;
  logic [OffsetW-1:0]     s2_off_q;

  // Stage 3: cluster count and data region base
  logic                   s3_valid_q;
  logic [ClusterW-1:0]    s3_cl_q;
  logic [EntryW-1:0]      s3_raw_q;
  logic [LbaW-1:0]        s3_tlba_q;
  logic [OffsetW-1:0]     s3_off_q;
  logic [ClusterW-1:0]    s3_count_q;
  logic [LbaW-1:0]        s3_base_q;

  logic [15:0]            data_secs;

  always_comb begin
    if ({9'd0, cfg_i.volume_sectors} > s2_fd_q) begin
      data_secs = cfg_i.volume_sectors - s2_fd_q[15:0];
    end else begin
      data_secs = 16'd0;
    end
  end

  // Stage 4: range check, data address, next cluster
  logic                   s4_valid_q;
  logic [LbaW-1:0]        s4_dlba_q;
  logic [LbaW-1:0]        s4_tlba_q;
  logic [OffsetW-1:0]     s4_off_q;
  logic                   s4_ok_q;
  logic [ClusterW-1:0]    s4_next_q;
  logic [ClusterW-1:0]    s4_count_q;

  logic                   ok;
  logic [ClusterW-1:0]    rel;
  logic [22:0]            rel_shl;
  logic [ClusterW-1:0]    next_d;

  always_comb begin
    ok      = (s3_cl_q >= FirstCluster) &&
              ({1'b0, s3_cl_q} < ({1'b0, s3_count_q} + {1'b0, FirstCluster}));
    rel     = s3_cl_q - FirstCluster;
    rel_shl = {7'd0, rel} << cfg_i.cluster_size_log2;
    if (ok && (s3_raw_q < EocMin)) begin
      next_d = s3_raw_q;
    end else begin
      next_d = EndMark;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cl_q   <= cluster_i;
    s1_raw_q  <= raw_entry_i;
    s1_prod_q <= cfg_i.fat_copies * cfg_i.fat_length;
    s1_root_q <= root_shr[RootSecW-1:0];
    s1_hi_q   <= hi_shr[7:0];
    s1_off_q  <= byte_off[OffsetW-1:0] & off_mask;

    s2_cl_q   <= s1_cl_q;
    s2_raw_q  <= s1_raw_q;
    s2_fd_q   <= {9'd0, cfg_i.reserved_sectors} + {1'b0, s1_prod_q}
                 + {12'd0, s1_root_q};
    s2_tlba_q <= cfg_i.partition_base + {16'd0, cfg_i.reserved_sectors}
                 + {24'd0, s1_hi_q};
    s2_off_q  <= s1_off_q;

    s3_cl_q    <= s2_cl_q;
    s3_raw_q   <= s2_raw_q;
    s3_tlba_q  <= s2_tlba_q;
    s3_off_q   <= s2_off_q;
    s3_count_q <= data_secs >> cfg_i.cluster_size_log2;
    s3_base_q  <= cfg_i.partition_base + {7'd0, s2_fd_q};

    s4_dlba_q  <= ok ? (s3_base_q + {9'd0, rel_shl}) : '0;
    s4_tlba_q  <= s3_tlba_q;
    s4_off_q   <= s3_off_q;
    s4_ok_q    <= ok;
    s4_next_q  <= next_d;
    s4_count_q <= s3_count_q;
  end

  assign out_valid_o     = s4_valid_q;
  assign data_lba_o      = s4_dlba_q;
  assign table_lba_o     = s4_tlba_q;
  assign entry_offset_o  = s4_off_q;
  assign in_range_o      = s4_ok_q;
  assign next_cluster_o  = s4_next_q;
  assign chain_end_o     = (s4_next_q == EndMark);
  assign cluster_count_o = s4_count_q;

endmodule

FILE: rtl/fat16_cluster_address_unit_top.sv
// Top level of the FAT16 cluster address unit.
`timescale 1ns / 1ps
//
// Translates a FAT16 cluster number into the LBA of its first data sector,
// the LBA and byte offset of its FAT entry, and the next cluster of the chain.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; cluster_i and raw_entry_i are sampled at that edge.
// Result channel: done_o is high for one cycle with all result ports valid;
// the receiver cannot stall, so results are never held or dropped.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at a
// rising edge; write only while no transaction is in flight.
// Pipeline: a transaction passes through four register stages (geometry
// product, first data sector, cluster count, range check), and done_o
// is high with its result after the last of them.
// Throughput: one transaction per cycle, back to back.
// Reset: registers return to their default geometry, the pipeline empties,
// and busy stays high until the first clock edge after reset release.
//
module fat16_cluster_address_unit_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [fca_pkg::ClusterW-1:0] cluster_i,
  input  logic [fca_pkg::EntryW-1:0]   raw_entry_i,
  output logic                         done_o,
  output logic [fca_pkg::LbaW-1:0]     data_lba_o,
  output logic [fca_pkg::LbaW-1:0]     table_lba_o,
  output logic [fca_pkg::OffsetW-1:0]  entry_offset_o,
  output logic                         in_range_o,
  output logic [fca_pkg::ClusterW-1:0] next_cluster_o,
  output logic                         chain_end_o,
  output logic [fca_pkg::ClusterW-1:0] cluster_count_o,
  input  logic                         cfg_we_i,
  input  logic [fca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fca_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import fca_pkg::*;

  cfg_t cfg;
  logic busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  fca_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fca_pipe u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (start && !busy_q),
    .cluster_i       (cluster_i),
    .raw_entry_i     (raw_entry_i),
    .out_valid_o     (done_o),
    .data_lba_o      (data_lba_o),
    .table_lba_o     (table_lba_o),
    .entry_offset_o  (entry_offset_o),
    .in_range_o      (in_range_o),
    .next_cluster_o  (next_cluster_o),
    .chain_end_o     (chain_end_o),
    .cluster_count_o (cluster_count_o)
  );

endmodule

FILE: rtl/fca_checker.sv
// Port-level checker for the FAT16 cluster address unit, bound to the top level.
`timescale 1ns / 1ps

module fca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] data_lba_o,
  input logic        in_range_o,
  input logic [15:0] next_cluster_o,
  input logic        chain_end_o,
  input logic [15:0] cluster_count_o
);

  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after reset");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start && !busy, 4))
    else $error("done does not match accepted transaction four cycles back");

  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !in_range_o |-> data_lba_o == 32'd0 && next_cluster_o == 16'hFFFF
      && chain_end_o)
    else $error("out-of-range transaction not terminated");

  a_in_range_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && in_range_o |-> cluster_count_o != 16'd0)
    else $error("in-range cluster with zero cluster count");

endmodule

bind fat16_cluster_address_unit_top fca_checker u_fca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .data_lba_o      (data_lba_o),
  .in_range_o      (in_range_o),
  .next_cluster_o  (next_cluster_o),
  .chain_end_o     (chain_end_o),
  .cluster_count_o (cluster_count_o)
);

FILE: bench/fat16_cluster_address_unit_top_test.sv
// Self-checking testbench for the FAT16 cluster address unit: directed plan, random geometry.
`timescale 1ns / 1ps

module fat16_cluster_address_unit_top_test;
  import fca_pkg::*;

  localparam int unsigned DirEntryBytes = 32;
  localparam int unsigned PlanRows      = 46;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 103;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned MaxReported   = 10;

  typedef struct packed {
    logic [LbaW-1:0]     data_lba;
    logic [LbaW-1:0]     table_lba;
    logic [OffsetW-1:0]  entry_offset;
    logic                in_range;
    logic [ClusterW-1:0] next_cluster;
    logic                chain_end;
    logic [ClusterW-1:0] cluster_count;
  } xlat_t;

  typedef enum logic {PlanItem, PlanReg} plan_kind_e;

  typedef struct packed {
    plan_kind_e          kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] word;
    logic [ClusterW-1:0] cluster;
    logic [EntryW-1:0]   raw;
    logic                known;
    xlat_t               want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ClusterW-1:0] cluster_i = '0;
  logic [EntryW-1:0]   raw_entry_i = '0;
  logic                done_o;
  logic [LbaW-1:0]     data_lba_o;
  logic [LbaW-1:0]     table_lba_o;
  logic [OffsetW-1:0]  entry_offset_o;
  logic                in_range_o;
  logic [ClusterW-1:0] next_cluster_o;
  logic                chain_end_o;
  logic [ClusterW-1:0] cluster_count_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  cfg_t        geometry;
  xlat_t       pending_xlats[$];
  plan_row_t   plan [PlanRows];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  bit          pace = 1'b1;

  fat16_cluster_address_unit_top u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cluster_i,
    .raw_entry_i,
    .done_o,
    .data_lba_o,
    .table_lba_o,
    .entry_offset_o,
    .in_range_o,
    .next_cluster_o,
    .chain_end_o,
    .cluster_count_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic xlat_t translate_cluster(input cfg_t g, input logic [ClusterW-1:0] cl,
                                              input logic [EntryW-1:0] raw);
    int unsigned shift;
    int unsigned root_secs;
    int unsigned first_data;
    int unsigned data_secs;
    int unsigned count;
    int unsigned byte_off;
    xlat_t x;
    if (g.sector_size_log2 < MinShift) begin
      shift = 32'(MinShift);
    end else if (g.sector_size_log2 > MaxShift) begin
      shift = 32'(MaxShift);
    end else begin
      shift = 32'(g.sector_size_log2);
    end
    root_secs  = (32'(g.root_entries) * DirEntryBytes + (32'd1 << shift) - 1) >> shift;
    first_data = 32'(g.reserved_sectors) + 32'(g.fat_copies) * 32'(g.fat_length) + root_secs;
    data_secs  = (32'(g.volume_sectors) > first_data) ? 32'(g.volume_sectors) - first_data : 0;
    count      = (data_secs >> g.cluster_size_log2) & 32'hFFFF;
    byte_off   = 32'(cl) * 2;
    x.in_range      = (cl >= FirstCluster) && (32'(cl) < count + 32'(FirstCluster));
    x.table_lba     = g.partition_base + 32'(g.reserved_sectors) + (byte_off >> shift);
    x.entry_offset  = 12'(byte_off & ((32'd1 << shift) - 1));
    x.cluster_count = 16'(count);
    if (x.in_range) begin
      x.data_lba     = g.partition_base + first_data
                       + ((32'(cl) - 32'(FirstCluster)) << g.cluster_size_log2);
      x.next_cluster = (raw >= EocMin) ? EndMark : raw;
    end else begin
      x.data_lba     = '0;
      x.next_cluster = EndMark;
    end
    x.chain_end = (x.next_cluster == EndMark);
    return x;
  endfunction

  function automatic void set_geometry_reg(input logic [CfgIdxW-1:0] idx,
                                           input logic [CfgDataW-1:0] word);
    case (idx)
      RegSectorLog2:  geometry.sector_size_log2  = word[ShiftW-1:0];
      RegClusterLog2: geometry.cluster_size_log2 = word[CshW-1:0];
      RegReserved:    geometry.reserved_sectors  = word[15:0];
      RegFatCopies:   geometry.fat_copies        = word[7:0];
      RegFatLength:   geometry.fat_length        = word[15:0];
      RegRootEntries: geometry.root_entries      = word[15:0];
      RegVolumeSecs:  geometry.volume_sectors    = word[15:0];
      RegPartBase:    geometry.partition_base    = word;
      default: ;
    endcase
  endfunction

  function automatic plan_row_t plan_reg(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] word);
    plan_row_t row;
    row      = '0;
    row.kind = PlanReg;
    row.idx  = idx;
    row.word = word;
    return row;
  endfunction

  function automatic plan_row_t plan_item(input logic [ClusterW-1:0] cl,
                                          input logic [EntryW-1:0] raw);
    plan_row_t row;
    row         = '0;
    row.kind    = PlanItem;
    row.cluster = cl;
    row.raw     = raw;
    return row;
  endfunction

  function automatic plan_row_t plan_known(input logic [ClusterW-1:0] cl,
                                           input logic [EntryW-1:0] raw,
                                           input logic [LbaW-1:0] lba,
                                           input logic [LbaW-1:0] tlba,
                                           input logic [OffsetW-1:0] off,
                                           input logic ir,
                                           input logic [ClusterW-1:0] nxt,
                                           input logic ce,
                                           input logic [ClusterW-1:0] cnt);
    plan_row_t row;
    row       = plan_item(cl, raw);
    row.known = 1'b1;
    row.want  = '{data_lba: lba, table_lba: tlba, entry_offset: off, in_range: ir,
                  next_cluster: nxt, chain_end: ce, cluster_count: cnt};
    return row;
  endfunction

  function automatic void flag(input string msg);
    if (failures < MaxReported) begin
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
    end
    failures++;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      flag($sformatf("%s expected %h, got %h", name, want, got));
    end
  endfunction

  task automatic issue(input logic [ClusterW-1:0] cl, input logic [EntryW-1:0] raw,
                       input xlat_t want);
    while (pace && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    cluster_i   <= cl;
    raw_entry_i <= raw;
    do @(posedge clk_i); while (busy);
    pending_xlats.push_back(want);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_xlats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] word);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    set_geometry_reg(idx, word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    xlat_t want;
    if (rst_ni && done_o) begin
      if (pending_xlats.size() == 0) begin
        flag("result with no transaction pending");
      end else begin
        want = pending_xlats.pop_front();
        check_field("data_lba", want.data_lba, data_lba_o);
        check_field("table_lba", want.table_lba, table_lba_o);
        check_field("entry_offset", 32'(want.entry_offset), 32'(entry_offset_o));
        check_field("in_range", 32'(want.in_range), 32'(in_range_o));
        check_field("next_cluster", 32'(want.next_cluster), 32'(next_cluster_o));
        check_field("chain_end", 32'(want.chain_end), 32'(chain_end_o));
        check_field("cluster_count", 32'(want.cluster_count), 32'(cluster_count_o));
      end
    end
  end

  initial begin : stimulus
    xlat_t               want;
    logic [ClusterW-1:0] cl;
    logic [EntryW-1:0]   raw;
    logic [ClusterW-1:0] last_next;
    logic [CfgIdxW-1:0]  ridx;
    logic [CfgDataW-1:0] word;
    logic [CfgDataW-1:0] noise;
    bit                  follow;
    int unsigned         span;
    int unsigned         hi;
    int unsigned         roll;

    geometry = '{sector_size_log2: 4'd9, cluster_size_log2: 3'd0, reserved_sectors: 16'd1,
                 fat_copies: 8'd2, fat_length: 16'd0, root_entries: 16'd512,
                 volume_sectors: 16'd0, partition_base: 32'd2048};

    plan = '{
      plan_known(16'h0000, 16'h0000, 32'd0, 32'd2049, 12'd0, 1'b0, 16'hFFFF, 1'b1, 16'd0),
      plan_known(16'hFFFF, 16'hFFFF, 32'd0, 32'd2304, 12'd510, 1'b0, 16'hFFFF, 1'b1, 16'd0),
      plan_known(16'h0002, 16'h0003, 32'd0, 32'd2049, 12'd4, 1'b0, 16'hFFFF, 1'b1, 16'd0),
      plan_reg(RegSectorLog2, 32'd0),
      plan_reg(RegClusterLog2, 32'd0),
      plan_reg(RegReserved, 32'd0),
      plan_reg(RegFatCopies, 32'd0),
      plan_reg(RegFatLength, 32'd0),
      plan_reg(RegRootEntries, 32'd0),
      plan_reg(RegVolumeSecs, 32'h0000_FFFF),
      plan_reg(RegPartBase, 32'd0),
      plan_known(16'h0002, 16'h0000, 32'd0, 32'd0, 12'd4, 1'b1, 16'h0000, 1'b0, 16'hFFFF),
      plan_known(16'hFFFF, 16'hFFF7, 32'd65533, 32'd255, 12'd510, 1'b1, 16'hFFF7, 1'b0,
                 16'hFFFF),
      plan_known(16'h0001, 16'h1234, 32'd0, 32'd0, 12'd2, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF),
      plan_known(16'h0003, 16'hFFF8, 32'd1, 32'd0, 12'd6, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF),
      plan_reg(RegSectorLog2, 32'hFFFF_FFFF),
      plan_reg(RegClusterLog2, 32'd3),
      plan_reg(RegReserved, 32'd32),
      plan_reg(RegFatCopies, 32'd2),
      plan_reg(RegFatLength, 32'd200),
      plan_reg(RegRootEntries, 32'd512),
      plan_reg(RegVolumeSecs, 32'd60000),
      plan_reg(RegPartBase, 32'hFFFF_F000),
      plan_item(16'd2, 16'hFFFF),
      plan_item(16'd7446, 16'd5),
      plan_item(16'd7447, 16'd6),
      plan_item(16'd4000, 16'd0),
      plan_item(16'hFFFF, 16'h8000),
      plan_reg(RegSectorLog2, 32'd12),
      plan_reg(RegFatCopies, 32'hFF),
      plan_reg(RegFatLength, 32'hFFFF),
      plan_item(16'd2, 16'd1),
      plan_item(16'hFFFE, 16'hFFF9),
      plan_reg(RegSectorLog2, 32'd10),
      plan_reg(RegClusterLog2, 32'd7),
      plan_reg(RegReserved, 32'd0),
      plan_reg(RegFatCopies, 32'd1),
      plan_reg(RegFatLength, 32'd1),
      plan_item(16'd469, 16'hABCD),
      plan_item(16'd470, 16'd2),
      plan_item(16'h5555, 16'hAAAA),
      plan_item(16'hAAAA, 16'h5555),
      plan_reg(RegSectorLog2, 32'd11),
      plan_item(16'd100, 16'hFFF8),
      plan_reg(RegRootEntries, 32'd1),
      plan_item(16'd2, 16'd0)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == PlanReg) begin
        settle();
        write_reg(plan[i].idx, plan[i].word);
      end else begin
        issue(plan[i].cluster, plan[i].raw, plan[i].known ? plan[i].want
              : translate_cluster(geometry, plan[i].cluster, plan[i].raw));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      for (int r = 0; r < 8; r++) begin
        ridx  = CfgIdxW'(r);
        noise = $urandom;
        case (ridx)
          RegSectorLog2: begin
            word = (noise << 4) | (($urandom_range(9) < 8) ? $urandom_range(12, 9)
                                                          : $urandom_range(15));
          end
          RegClusterLog2: begin
            word = (noise << 3) | $urandom_range(7);
          end
          RegReserved: begin
            word = (noise << 16) | (($urandom_range(9) < 7) ? $urandom_range(64)
                                                           : $urandom_range(65535));
          end
          RegFatCopies: begin
            roll = $urandom_range(9);
            word = (noise << 8) | ((roll < 6) ? $urandom_range(2, 1)
                                 : (roll < 7) ? 0 : $urandom_range(255));
          end
          RegFatLength: begin
            word = (noise << 16) | (($urandom_range(9) < 7) ? $urandom_range(256)
                                                           : $urandom_range(65535));
          end
          RegRootEntries: begin
            word = (noise << 16) | (($urandom_range(9) < 7) ? $urandom_range(1024)
                                                           : $urandom_range(65535));
          end
          RegVolumeSecs: begin
            word = (noise << 16) | (($urandom_range(9) < 7) ? $urandom_range(65535, 40000)
                                                           : $urandom_range(65535));
          end
          default: begin
            roll = $urandom_range(3);
            word = (roll < 2) ? $urandom_range(32'h0010_0000)
                 : (roll < 3) ? 32'hFFFF_FFFF - $urandom_range(65535) : noise;
          end
        endcase
        if (p == 0) begin
          word = '0;
        end else if (p == 1) begin
          word = '1;
        end
        write_reg(ridx, word);
      end

      pace   = !(p == 3 || p == 4);
      span   = 32'(translate_cluster(geometry, '0, '0).cluster_count);
      hi     = (span >= 65534) ? 65535 : span + 1;
      follow = 1'b0;
      last_next = '0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        roll = $urandom_range(99);
        if (roll < 45 && span != 0) begin
          cl = ClusterW'($urandom_range(hi, 2));
        end else if (roll < 60 && follow) begin
          cl = last_next;
        end else if (roll < 80) begin
          case ($urandom_range(7))
            0:       cl = 16'd0;
            1:       cl = 16'd1;
            2:       cl = 16'd2;
            3:       cl = ClusterW'(span);
            4:       cl = ClusterW'(span + 1);
            5:       cl = ClusterW'(span + 2);
            6:       cl = 16'hFFFE;
            default: cl = 16'hFFFF;
          endcase
        end else begin
          cl = ClusterW'($urandom);
        end

        roll = $urandom_range(99);
        if (roll < 20) begin
          raw = EntryW'($urandom_range(16'hFFFF, 16'hFFF8));
        end else if (roll < 25) begin
          raw = 16'hFFF7;
        end else if (roll < 30) begin
          raw = '0;
        end else if (roll < 60 && span != 0) begin
          raw = EntryW'($urandom_range(hi, 2));
        end else begin
          raw = EntryW'($urandom);
        end

        want = translate_cluster(geometry, cl, raw);
        issue(cl, raw, want);
        follow    = !want.chain_end;
        last_next = want.next_cluster;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: fat16_cluster_address_unit_top.f
rtl/fca_pkg.sv
rtl/fca_cfg_regs.sv
rtl/fca_pipe.sv
rtl/fat16_cluster_address_unit_top.sv
rtl/fca_checker.sv
bench/fat16_cluster_address_unit_top_test.sv
